FILE: hdl/iad_pkg.sv
// Shared types and constants of the integer-to-ASCII digit unit.
// Used by iad_digit_cell, iad_ctrl and integer_to_ascii_digits_unit.
`timescale 1ns / 1ps

package iad_pkg;

    // Mode codes carried in s_tuser. Code 3 is handled as unsigned decimal.
    localparam logic [1:0] MODE_SIGNED   = 2'd0;
    localparam logic [1:0] MODE_UNSIGNED = 2'd1;
    localparam logic [1:0] MODE_HEX      = 2'd2;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [3:0] DEC_BASE = 4'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_CONVERT,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     hex;
    } cell_ctrl_t;

    function automatic logic [7:0] digit_to_char(input logic [3:0] d);
        logic [7:0] wide;
        wide = {4'b0000, d};
        if (d < DEC_BASE)
        begin
            return CH_ZERO + wide;
        end
        return CH_A + wide - {4'b0000, DEC_BASE};
    endfunction

endpackage

FILE: hdl/integer_to_ascii_digits_unit.sv
// Top level of the integer-to-ASCII digit unit: a row of digit cells driven
// by the sequencer. Depends on iad_pkg, iad_digit_cell and iad_ctrl.
//
//   channel  | direction | tdata                 | tuser / tlast
//   ---------+-----------+-----------------------+----------------------
//   s_*      | in        | value (VALUE_WIDTH)   | tuser: mode (2 bits)
//   m_*      | out       | char_code (8 bits)    | tlast: last_char
//
// An item is taken in and its VALUE_WIDTH bits are shifted into the cell row.
// Leading zero digits are then dropped (the last digit is always kept), a minus
// sign is sent when the value is negative, and the digits follow it.
// One item is in work at a time; s_tready is high only when the unit is idle.
// A stall on m_tready holds the output register and pauses the character feed.
// Reset (rst_n, asynchronous) returns the sequencer to idle with no item held.
`timescale 1ns / 1ps

module integer_to_ascii_digits_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata, // value
    input  logic [1:0]                            s_tuser, // mode
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [7:0]                            m_tdata, // char_code
    output logic                                  m_tlast
);

    // Decimal digits of 2^VALUE_WIDTH-1 (1233/4096 approximates log10 of 2).
    localparam int DEC_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
    localparam int NUM_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;

    iad_pkg::cell_ctrl_t cell_ctrl;
    logic                ser_bit;
    logic [3:0]          digit [NUM_DIGITS];
    logic                carry [NUM_DIGITS];

    iad_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NUM_DIGITS  (NUM_DIGITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata[VALUE_WIDTH-1:0]),
        .in_mode   (s_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .out_last  (m_tlast),
        .cell_ctrl (cell_ctrl),
        .ser_bit   (ser_bit),
        .top_digit (digit[NUM_DIGITS-1])
    );

    // Cell 0 holds the least significant digit; data moves toward the top.
    for (genvar i = 0; i < NUM_DIGITS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            iad_digit_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl),
                .carry_in  (ser_bit),
                .digit_in  (4'd0),
                .carry_out (carry[i]),
                .digit     (digit[i])
            );
        end
        else
        begin : g_next
            iad_digit_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl),
                .carry_in  (carry[i-1]),
                .digit_in  (digit[i-1]),
                .carry_out (carry[i]),
                .digit     (digit[i])
            );
        end
    end

endmodule

FILE: hdl/iad_digit_cell.sv
// One digit cell of the conversion row: a 4-bit BCD or hex digit.
// Depends on iad_pkg for the cell control struct.
`timescale 1ns / 1ps

module iad_digit_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  iad_pkg::cell_ctrl_t ctrl,
    input  logic              carry_in,
    input  logic [3:0]        digit_in,
    output logic              carry_out,
    output logic [3:0]        digit
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    // Double-dabble correction: a decimal digit of five or more gets three
    // added before the shift, so that it carries into the next cell.
    always_comb
    begin
        if (!ctrl.hex && (digit_reg >= 4'd5))
        begin
            adj = digit_reg + 4'd3;
        end
        else
        begin
            adj = digit_reg;
        end
    end

    assign carry_out = adj[3];

    always_comb
    begin
        unique case (ctrl.op)
            iad_pkg::CELL_HOLD:    digit_next = digit_reg;
            iad_pkg::CELL_CLEAR:   digit_next = 4'd0;
            iad_pkg::CELL_CONVERT: digit_next = {adj[2:0], carry_in};
            iad_pkg::CELL_SHIFT:   digit_next = digit_in;
            default:               digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= 4'd0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

    assign digit = digit_reg;

endmodule

FILE: hdl/iad_ctrl.sv
// Sequencer of the digit unit: sign handling, serial feed of the magnitude,
// leading-zero skip and the character output register. Depends on iad_pkg.
`timescale 1ns / 1ps

module iad_ctrl #(
    parameter int VALUE_WIDTH = 32,
    parameter int NUM_DIGITS  = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [VALUE_WIDTH-1:0] in_value,
    input  logic [1:0]             in_mode,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             out_char,
    output logic                   out_last,
    output iad_pkg::cell_ctrl_t    cell_ctrl,
    output logic                   ser_bit,
    input  logic [3:0]             top_digit
);

    localparam int CNT_W = $clog2(VALUE_WIDTH);
    localparam int REM_W = $clog2(NUM_DIGITS + 1);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(VALUE_WIDTH - 1);
    localparam logic [REM_W-1:0] REM_ONE  = REM_W'(1);
    localparam logic [REM_W-1:0] REM_FULL = REM_W'(NUM_DIGITS);

    iad_pkg::state_t state_reg, state_next;

    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [CNT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic                   neg_reg, neg_next;
    logic                   hex_reg, hex_next;
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             out_char_reg, out_char_next;
    logic                   out_last_reg, out_last_next;

    logic       accept;
    logic       out_free;
    logic       in_neg;
    logic       load_out;
    logic [7:0] load_char;
    logic       load_last;
    iad_pkg::cell_op_t cell_op;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign in_neg   = (in_mode == iad_pkg::MODE_SIGNED) && in_value[VALUE_WIDTH-1];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            iad_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = iad_pkg::ST_CONVERT;
                end
            end
            iad_pkg::ST_CONVERT:
            begin
                if (bit_cnt_reg == LAST_BIT)
                begin
                    state_next = iad_pkg::ST_SKIP;
                end
            end
            iad_pkg::ST_SKIP:
            begin
                if ((top_digit != 4'd0) || (rem_reg == REM_ONE))
                begin
                    state_next = neg_reg ? iad_pkg::ST_SIGN : iad_pkg::ST_EMIT;
                end
            end
            iad_pkg::ST_SIGN:
            begin
                if (out_free)
                begin
                    state_next = iad_pkg::ST_EMIT;
                end
            end
            iad_pkg::ST_EMIT:
            begin
                if (out_free && (rem_reg == REM_ONE))
                begin
                    state_next = iad_pkg::ST_IDLE;
                end
            end
            default: state_next = iad_pkg::ST_IDLE;
        endcase
    end

    // Control outputs of each state.
    always_comb
    begin
        in_ready  = 1'b0;
        cell_op   = iad_pkg::CELL_HOLD;
        load_out  = 1'b0;
        load_char = iad_pkg::digit_to_char(top_digit);
        load_last = (rem_reg == REM_ONE);
        unique case (state_reg)
            iad_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cell_op = iad_pkg::CELL_CLEAR;
                end
            end
            iad_pkg::ST_CONVERT:
            begin
                cell_op = iad_pkg::CELL_CONVERT;
            end
            iad_pkg::ST_SKIP:
            begin
                if ((top_digit == 4'd0) && (rem_reg != REM_ONE))
                begin
                    cell_op = iad_pkg::CELL_SHIFT;
                end
            end
            iad_pkg::ST_SIGN:
            begin
                load_out  = out_free;
                load_char = iad_pkg::CH_MINUS;
                load_last = 1'b0;
            end
            iad_pkg::ST_EMIT:
            begin
                load_out = out_free;
                if (out_free)
                begin
                    cell_op = iad_pkg::CELL_SHIFT;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign cell_ctrl.op  = cell_op;
    assign cell_ctrl.hex = hex_reg;
    assign ser_bit       = mag_reg[VALUE_WIDTH-1];

    // Datapath registers.
    always_comb
    begin
        mag_next       = mag_reg;
        bit_cnt_next   = bit_cnt_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        hex_next       = hex_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        if (accept)
        begin
            mag_next     = in_neg ? (~in_value + 1'b1) : in_value;
            neg_next     = in_neg;
            hex_next     = (in_mode == iad_pkg::MODE_HEX);
            bit_cnt_next = '0;
        end

        if (state_reg == iad_pkg::ST_CONVERT)
        begin
            mag_next     = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 1'b1;
            rem_next     = REM_FULL;
        end

        if (cell_op == iad_pkg::CELL_SHIFT)
        begin
            rem_next = rem_reg - 1'b1;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_char_next  = load_char;
            out_last_next  = load_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iad_pkg::ST_IDLE;
            bit_cnt_reg   <= '0;
            rem_reg       <= '0;
            neg_reg       <= 1'b0;
            hex_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            rem_reg       <= rem_next;
            neg_reg       <= neg_next;
            hex_reg       <= hex_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

    // An accepted item always starts a fresh conversion at bit zero.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == iad_pkg::ST_CONVERT) && (bit_cnt_reg == '0))
        else $error("accepted item did not start a conversion");

    // The digit count never runs out while digits are skipped or sent.
    a_rem_live: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == iad_pkg::ST_SKIP) || (state_reg == iad_pkg::ST_EMIT))
        |-> (rem_reg != '0))
        else $error("digit count empty while emitting");

    // A minus sign is never the final character of a number.
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_last_reg && (out_char_reg == iad_pkg::CH_MINUS)))
        else $error("minus sign flagged as last character");

    // The final character of a number closes the item and frees the input.
    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == iad_pkg::ST_EMIT) && load_out && load_last)
        |=> (state_reg == iad_pkg::ST_IDLE) && out_valid_reg && out_last_reg)
        else $error("last character did not end the item");

endmodule

FILE: verif/iad_text_monitor.sv
// Scoreboard for the integer-to-ASCII digit unit: watches both stream channels,
// predicts the characters of every accepted number and checks each output item.
// Depends on iad_pkg for the mode codes and character constants.
`timescale 1ns / 1ps

module iad_text_monitor #(
    parameter int VALUE_WIDTH = 32,
    parameter int TDATA_W     = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata, // value
    input  logic [1:0]         s_tuser, // mode
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [7:0]         m_tdata, // char_code
    input  logic               m_tlast,
    output int                 error_count,
    output int                 pending_chars,
    output int                 numbers_seen,
    output int                 chars_seen
);

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } text_char_t;

    text_char_t expected_text[$];
    text_char_t want;
    int errors  = 0;
    int numbers = 0;
    int chars   = 0;

    assign error_count   = errors;
    assign pending_chars = expected_text.size();
    assign numbers_seen  = numbers;
    assign chars_seen    = chars;

    // Queues the text of one number, sign first, then digits most significant first.
    function automatic void predict_number_text(input logic [TDATA_W-1:0] raw,
                                                input logic [1:0] mode);
        logic [63:0] mask;
        logic [63:0] mag;
        logic [63:0] radix;
        logic [63:0] rem;
        logic [7:0]  digs [0:23];
        bit          neg;
        int          n;
        text_char_t  c;
        mask  = (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
        mag   = 64'(raw) & mask;
        radix = (mode == iad_pkg::MODE_HEX) ? 64'd16 : 64'd10;
        neg   = (mode == iad_pkg::MODE_SIGNED) && mag[VALUE_WIDTH-1];
        // The most negative value wraps back onto itself, which is the magnitude wanted.
        if (neg)
        begin
            mag = (64'd0 - mag) & mask;
        end
        for (n = 0; n == 0 || (mag != 64'd0 && n < 24); n++)
        begin
            rem = mag % radix;
            digs[n] = (rem < 64'd10) ? iad_pkg::CH_ZERO + rem[7:0]
                                     : iad_pkg::CH_A + rem[7:0] - 8'd10;
            mag = mag / radix;
        end
        if (neg)
        begin
            c.code = iad_pkg::CH_MINUS;
            c.last = 1'b0;
            expected_text.push_back(c);
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            c.code = digs[i];
            c.last = (i == 0);
            expected_text.push_back(c);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // Output side first: a number taken in this cycle cannot answer in it.
            if (m_tvalid && m_tready)
            begin
                chars++;
                if (expected_text.size() == 0)
                begin
                    $error("char_code: expected nothing, got %02h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (m_tdata !== want.code)
                    begin
                        $error("char_code: expected %02h, got %02h", want.code, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_char: expected %0b, got %0b", want.last, m_tlast);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                numbers++;
                predict_number_text(s_tdata, s_tuser);
            end
        end
    end

endmodule

FILE: verif/integer_to_ascii_digits_unit_tb.sv
// Top of the integer-to-ASCII digit unit testbench: clock, reset, number stimulus,
// output back-pressure, watchdog and verdict. Depends on iad_pkg, the unit and
// iad_text_monitor.
`timescale 1ns / 1ps

module integer_to_ascii_digits_unit_tb;

    localparam int VALUE_WIDTH    = 32;
    localparam int TDATA_W        = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int RANDOM_NUMBERS = 207;
    localparam int LONG_HOLD      = 200;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 60;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0; // value
    logic [1:0]         s_tuser  = iad_pkg::MODE_SIGNED; // mode
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [7:0]         m_tdata; // char_code
    logic               m_tlast;

    int error_count;
    int pending_chars;
    int numbers_seen;
    int chars_seen;
    int src_idle_pct = 9;
    int sink_idle_pct = 68;
    int stall_cycles = 0;
    bit long_hold_pending = 1'b0;
    bit long_hold_done = 1'b0;

    integer_to_ascii_digits_unit #(.VALUE_WIDTH(VALUE_WIDTH)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    iad_text_monitor #(.VALUE_WIDTH(VALUE_WIDTH)) text_mon (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .error_count   (error_count),
        .pending_chars (pending_chars),
        .numbers_seen  (numbers_seen),
        .chars_seen    (chars_seen)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Offers one number, idling first at the current sender rate.
    task automatic send_number(input logic [31:0] value, input logic [1:0] mode);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(value);
        s_tuser  <= mode;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    // Values weighted toward digit-count and sign boundaries.
    function automatic logic [31:0] pick_value();
        logic [31:0] pow10;
        int          k;
        case ($urandom_range(0, 5))
            0: pick_value = $urandom_range(0, 20);
            1: pick_value = 32'h8000_0000 + $urandom_range(0, 3) - 32'd2;
            2:
            begin
                pow10 = 32'd1;
                k = $urandom_range(1, 9);
                for (int i = 0; i < k; i++)
                begin
                    pow10 = pow10 * 32'd10;
                end
                pick_value = pow10 + $urandom_range(0, 2) - 32'd1;
            end
            3: pick_value = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
            4: pick_value = 32'hFFFF_FFFF - $urandom_range(0, 20);
            default: pick_value = $urandom();
        endcase
    endfunction

    function automatic logic [1:0] pick_mode();
        case ($urandom_range(0, 9))
            0, 1, 2: pick_mode = iad_pkg::MODE_SIGNED;
            3, 4, 5: pick_mode = iad_pkg::MODE_UNSIGNED;
            6, 7, 8: pick_mode = iad_pkg::MODE_HEX;
            default: pick_mode = MODE_SPARE;
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_number(pick_value(), pick_mode());
        end
    endtask

    // Output side: random back-pressure, plus one long hold on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold_pending && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // Watchdog over cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles = stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("integer_to_ascii_digits_unit_tb: errors");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed numbers: zero, one-digit, sign edges, extremes and the spare mode.
        send_number(32'd0,          iad_pkg::MODE_SIGNED);
        send_number(32'd9,          iad_pkg::MODE_SIGNED);
        send_number(32'd10,         iad_pkg::MODE_SIGNED);
        send_number(32'hFFFF_FFFF,  iad_pkg::MODE_SIGNED);
        send_number(32'hFFFF_FFF6,  iad_pkg::MODE_SIGNED);
        send_number(32'h7FFF_FFFF,  iad_pkg::MODE_SIGNED);
        send_number(32'h8000_0000,  iad_pkg::MODE_SIGNED);
        send_number(32'h8000_0001,  iad_pkg::MODE_SIGNED);
        send_number(32'd0,          iad_pkg::MODE_UNSIGNED);
        send_number(32'd1,          iad_pkg::MODE_UNSIGNED);
        send_number(32'd999999999,  iad_pkg::MODE_UNSIGNED);
        send_number(32'd1000000000, iad_pkg::MODE_UNSIGNED);
        send_number(32'h8000_0000,  iad_pkg::MODE_UNSIGNED);
        send_number(32'hFFFF_FFFF,  iad_pkg::MODE_UNSIGNED);
        send_number(32'd0,          iad_pkg::MODE_HEX);
        send_number(32'd15,         iad_pkg::MODE_HEX);
        send_number(32'd16,         iad_pkg::MODE_HEX);
        send_number(32'hABCD_EF01,  iad_pkg::MODE_HEX);
        send_number(32'h8000_0000,  iad_pkg::MODE_HEX);
        send_number(32'hFFFF_FFFF,  iad_pkg::MODE_HEX);
        send_number(32'd0,          MODE_SPARE);
        send_number(32'd12345,      MODE_SPARE);
        send_number(32'hFFFF_FFFF,  MODE_SPARE);

        send_random(RANDOM_NUMBERS / 3);

        src_idle_pct  = 68;
        sink_idle_pct = 9;
        send_random(RANDOM_NUMBERS / 3);

        // No idling; the output holds off for a while so the input backs up.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        long_hold_pending = 1'b1;
        send_random(RANDOM_NUMBERS - 2 * (RANDOM_NUMBERS / 3));
        s_tvalid <= 1'b0;

        while (pending_chars != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_chars != 0)
        begin
            $error("%0d expected characters never arrived", pending_chars);
        end
        $display("Converted %0d numbers into %0d characters in all four mode codes,",
                 numbers_seen, chars_seen);
        $display("under three idling mixes and one long output hold-off.");
        if (error_count == 0 && pending_chars == 0)
        begin
            $display("integer_to_ascii_digits_unit_tb: clean");
        end
        else
        begin
            $display("integer_to_ascii_digits_unit_tb: errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/iad_pkg.sv
hdl/iad_digit_cell.sv
hdl/iad_ctrl.sv
hdl/integer_to_ascii_digits_unit.sv
verif/iad_text_monitor.sv
verif/integer_to_ascii_digits_unit_tb.sv
